// ===== rtl/core/hpmp_pkg.sv =====
// Shared widths, register indexes and reset values for the hand pose motion predictor.
// No dependencies; every module of the block imports it.
`default_nettype none
package hpmp_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int WORD_W    = 32;
    localparam int WIDE_W    = 64;
    localparam int LIM_W     = 31;
    localparam int GRIP_W    = 17;
    localparam int PER_W     = 10;
    localparam int CFG_IDX_W = 3;
    localparam int SQRT_ITER = WIDE_W / 2;
    localparam int DIV_ITER  = WIDE_W;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD = 3'd0,
        CFG_SPEED  = 3'd1,
        CFG_ACCEL  = 3'd2,
        CFG_TURN   = 3'd3,
        CFG_GRIP   = 3'd4,
        CFG_PGAIN  = 3'd5,
        CFG_DGAIN  = 3'd6
    } t_cfg_idx;

    localparam logic [PER_W-1:0] PERIOD_ZERO_MS = 10'd16;
    localparam logic [PER_W-1:0] RST_PERIOD     = 10'd16;
    localparam logic [LIM_W-1:0] RST_SPEED      = 31'd78643;
    localparam logic [LIM_W-1:0] RST_ACCEL      = 31'd393216;
    localparam logic [LIM_W-1:0] RST_TURN       = 31'd209715;
    localparam logic [LIM_W-1:0] RST_GRIP       = 31'd262144;
    localparam logic [LIM_W-1:0] RST_PGAIN      = 31'd589824;
    localparam logic [LIM_W-1:0] RST_DGAIN      = 31'd157286;

endpackage
`default_nettype wire

// ===== rtl/core/hpmp_mul.sv =====
// Shared 32 x 32 unsigned multiplier with a registered product.
// Depends on hpmp_pkg for word widths.
`default_nettype none
module hpmp_mul import hpmp_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic [WORD_W-1:0] i_a,
    input  wire logic [WORD_W-1:0] i_b,
    output logic      [WIDE_W-1:0] o_p
);

    logic [WIDE_W-1:0] r_p;

    // register the product for use in the next cycle
    always_ff @(posedge i_clk) begin
        r_p <= WIDE_W'(i_a) * WIDE_W'(i_b);
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

// ===== rtl/core/hpmp_div.sv =====
// Restoring divider, 64-bit numerator by 32-bit divisor, one quotient bit a cycle.
// Depends on hpmp_pkg for widths and iteration count.
`default_nettype none
module hpmp_div import hpmp_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [WIDE_W-1:0] i_num,
    input  wire logic [WORD_W-1:0] i_den,
    output logic                   o_done,
    output logic      [WIDE_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(DIV_ITER);

    logic [WIDE_W-1:0] r_q;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [WORD_W:0]   trial;
    logic              fits;

    assign trial = {r_rem, r_q[WIDE_W-1]};
    assign fits  = (trial >= {1'b0, r_den});

    // shift one numerator bit into the remainder each cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= fits ? WORD_W'(trial - {1'b0, r_den}) : trial[WORD_W-1:0];
                r_q   <= {r_q[WIDE_W-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule
`default_nettype wire

// ===== rtl/core/hpmp_sqrt.sv =====
// Floor integer square root of a 64-bit value, two radicand bits a cycle.
// Depends on hpmp_pkg for widths and iteration count.
`default_nettype none
module hpmp_sqrt import hpmp_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [WIDE_W-1:0] i_rad,
    output logic                   o_done,
    output logic      [WORD_W-1:0] o_root
);

    localparam int CNT_W = $clog2(SQRT_ITER);

    logic [WIDE_W-1:0] r_n;
    logic [WIDE_W-1:0] r_r;
    logic [WIDE_W-1:0] r_bit;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [WIDE_W-1:0] trial;

    assign trial = r_r + r_bit;

    // settle one root bit per cycle, top bit first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_n    <= i_rad;
                r_r    <= '0;
                r_bit  <= WIDE_W'(1) << (WIDE_W - 2);
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_n >= trial) begin
                    r_n <= r_n - trial;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQRT_ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[WORD_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/core/hand_pose_motion_predictor_unit.sv =====
// Hand pose motion predictor: sequencer, pose state and datapath around shared units.
// Depends on hpmp_pkg, hpmp_mul, hpmp_div and hpmp_sqrt.
//
//  channel  | direction | handshake                  | word
//  ---------+-----------+----------------------------+------------------------------
//  input    | in        | i_in_valid / o_in_ready    | func, goal pose, tolerance, hold
//  output   | out       | o_out_valid / i_out_ready  | time, pose, error, reached, conf
//  config   | in        | i_cfg_we (no wait)         | i_cfg_addr, i_cfg_wdata
//
// A step under hold computes two vector lengths. A free step runs 10 to 16 divisions on the
// divider and four lengths on the square root.
// Reset is synchronous and active low; it restores register defaults and zero state.
// A result waits in the output register; the next word is taken meanwhile.
`default_nettype none
module hand_pose_motion_predictor_unit import hpmp_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [LIM_W-1:0]      i_cfg_wdata,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_func,
    input  wire logic [WORD_W-1:0]     i_goal_time,
    input  wire logic signed [WORD_W-1:0] i_goal_x,
    input  wire logic signed [WORD_W-1:0] i_goal_y,
    input  wire logic signed [WORD_W-1:0] i_goal_z,
    input  wire logic signed [WORD_W-1:0] i_goal_yaw,
    input  wire logic signed [WORD_W-1:0] i_goal_pitch,
    input  wire logic signed [WORD_W-1:0] i_goal_roll,
    input  wire logic [GRIP_W-1:0]     i_goal_grip,
    input  wire logic [LIM_W-1:0]      i_goal_tolerance,
    input  wire logic                  i_hold,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [WORD_W-1:0]          o_now_ms,
    output logic signed [WORD_W-1:0]   o_pos_x,
    output logic signed [WORD_W-1:0]   o_pos_y,
    output logic signed [WORD_W-1:0]   o_pos_z,
    output logic signed [WORD_W-1:0]   o_ang_yaw,
    output logic signed [WORD_W-1:0]   o_ang_pitch,
    output logic signed [WORD_W-1:0]   o_ang_roll,
    output logic [GRIP_W-1:0]          o_grip_level,
    output logic [WORD_W-1:0]          o_pose_error,
    output logic                       o_reached,
    output logic [GRIP_W-1:0]          o_confidence
);

    // fixed-point constants
    localparam logic [WIDE_W-1:0] QONE    = WIDE_W'(1) << FRAC_BITS;
    localparam logic [WIDE_W-1:0] QHALF   = QONE >> 1;
    localparam logic [WIDE_W-1:0] K_TOL   = (QONE + 64'd50) / 64'd100;
    localparam logic [WIDE_W-1:0] K_ROTW  = (QONE * 64'd2 + 64'd5) / 64'd10;
    localparam logic [WIDE_W-1:0] K_GRIPW = (QONE + 64'd5) / 64'd10;
    localparam logic [WIDE_W-1:0] K_BASE  = (QONE * 64'd65 + 64'd50) / 64'd100;
    localparam logic [WIDE_W-1:0] K_SLOPE = QONE / 64'd4;
    localparam logic [WIDE_W-1:0] K_HIGH  = (QONE * 64'd98 + 64'd50) / 64'd100;
    localparam logic [WIDE_W-1:0] K_LOW   = (QONE * 64'd2 + 64'd5) / 64'd10;
    localparam logic [WIDE_W-1:0] K_LOADC = (QONE * 64'd85 + 64'd50) / 64'd100;
    localparam logic [WIDE_W-1:0] MS_PER_S = 64'd1000;
    localparam logic [WIDE_W-1:0] MS_HALF  = 64'd500;
    localparam logic [WIDE_W-1:0] M32      = 64'hFFFF_FFFF;

    typedef enum logic [4:0] {
        S_IDLE, S_RATE_M, S_RATE_D, S_RATE_P, S_PD_A, S_PD_B, S_PD_C,
        S_SQ_M, S_SQ_A, S_SQ_S, S_SQW, S_SC_M, S_SC_D, S_SC_P, S_DV,
        S_VEL, S_AC_M, S_AC_D, S_AC_P, S_ST_M, S_ST_D, S_ST_P, S_TURN,
        S_ERR_L, S_ERR_R, S_ERR_G, S_ERR_F, S_CONF_M, S_CONF_P, S_DONE, S_DIVW
    } t_state;

    typedef enum logic [1:0] {PH_DSR, PH_DV, PH_EP, PH_EA} t_phase;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] mag32(input logic signed [WORD_W-1:0] v);
        return v[WORD_W-1] ? (~v + 1'b1) : v;
    endfunction

    // round a Q product to nearest, ties away from zero, and apply the sign
    function automatic logic signed [WIDE_W-1:0] mulq_fin(input logic [WIDE_W-1:0] p,
                                                           input logic neg);
        logic [WIDE_W-1:0] r;
        r = (p + QHALF) >> FRAC_BITS;
        return neg ? -$signed(r) : $signed(r);
    endfunction

    // configuration
    logic [PER_W-1:0] r_period;
    logic [LIM_W-1:0] r_speed, r_accel, r_turn, r_gripr, r_pgain, r_dgain;

    // pose state
    logic [WORD_W-1:0]        r_time;
    logic signed [WORD_W-1:0] r_pos [3];
    logic signed [WORD_W-1:0] r_vel [3];
    logic signed [WORD_W-1:0] r_acc [3];
    logic signed [WORD_W-1:0] r_ang [3];
    logic [GRIP_W-1:0]        r_grip;
    logic [WORD_W-1:0]        r_err;
    logic                     r_reach;
    logic [GRIP_W-1:0]        r_conf;

    // captured word and working values
    logic signed [WORD_W-1:0] r_g [3];
    logic signed [WORD_W-1:0] r_ga [3];
    logic [GRIP_W-1:0]        r_gg;
    logic [LIM_W-1:0]         r_tol;
    logic                     r_hold;
    logic signed [WORD_W-1:0] r_vec [3];
    logic [WORD_W-1:0]        r_lim [4];
    logic signed [WIDE_W-1:0] r_t;
    logic [WIDE_W-1:0]        r_sum;
    logic [WORD_W-1:0]        r_len;
    logic [WORD_W-1:0]        r_elen;
    logic [WIDE_W-1:0]        r_esum;
    logic [1:0]               r_ax;
    logic [1:0]               r_k;
    t_state                   r_st;
    t_state                   r_ret;
    t_phase                   r_ph;

    // output register
    logic                     r_ovalid;
    logic [WORD_W-1:0]        r_o_time;
    logic signed [WORD_W-1:0] r_o_pos [3];
    logic signed [WORD_W-1:0] r_o_ang [3];
    logic [GRIP_W-1:0]        r_o_grip;
    logic [WORD_W-1:0]        r_o_err;
    logic                     r_o_reach;
    logic [GRIP_W-1:0]        r_o_conf;

    // shared unit hookup
    logic [WORD_W-1:0] mul_a, mul_b;
    logic [WIDE_W-1:0] mul_p;
    logic              div_start, div_done;
    logic [WIDE_W-1:0] div_num, div_quo;
    logic [WORD_W-1:0] div_den;
    logic              sq_start, sq_done;
    logic [WORD_W-1:0] sq_root;

    logic [PER_W-1:0]         per;
    logic [WORD_W-1:0]        cap;
    logic                     in_acc;
    logic signed [WIDE_W-1:0] grip_d;
    logic signed [WIDE_W-1:0] conf_d;
    logic signed [WORD_W-1:0] pd_e;
    logic [WIDE_W-1:0]        div_qs_mag;

    assign per    = (r_period == '0) ? PERIOD_ZERO_MS : r_period;
    assign cap    = (r_ph == PH_DSR) ? {1'b0, r_speed} : r_lim[0];
    assign in_acc = i_in_valid && o_in_ready;
    assign grip_d = $signed(WIDE_W'(r_gg)) - $signed(WIDE_W'(r_grip));
    assign conf_d = $signed(QONE) - $signed(WIDE_W'(r_err));
    assign pd_e   = sat32(WIDE_W'(r_g[r_ax]) - WIDE_W'(r_pos[r_ax]));
    assign div_qs_mag = div_quo;

    hpmp_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    hpmp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    hpmp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (r_sum),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // steer the multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_st)
            S_RATE_M: begin
                mul_b = WORD_W'(per);
                unique case (r_k)
                    2'd0:    mul_a = WORD_W'(r_accel);
                    2'd1:    mul_a = WORD_W'(r_speed);
                    2'd2:    mul_a = WORD_W'(r_turn);
                    default: mul_a = WORD_W'(r_gripr);
                endcase
            end
            S_PD_A: begin
                mul_a = mag32(pd_e);
                mul_b = WORD_W'(r_pgain);
            end
            S_PD_B: begin
                mul_a = mag32(r_vel[r_ax]);
                mul_b = WORD_W'(r_dgain);
            end
            S_SQ_M: begin
                mul_a = mag32(r_vec[r_ax]);
                mul_b = mag32(r_vec[r_ax]);
            end
            S_SC_M: begin
                mul_a = mag32(r_vec[r_ax]);
                mul_b = cap;
            end
            S_AC_M: begin
                mul_a = mag32(r_vec[r_ax]);
                mul_b = MS_PER_S[WORD_W-1:0];
            end
            S_ST_M: begin
                mul_a = mag32(r_vel[r_ax]);
                mul_b = WORD_W'(per);
            end
            S_ERR_R: begin
                mul_a = r_len;
                mul_b = K_ROTW[WORD_W-1:0];
            end
            S_ERR_G: begin
                mul_a = grip_d[WIDE_W-1] ? WORD_W'(-grip_d) : WORD_W'(grip_d);
                mul_b = K_GRIPW[WORD_W-1:0];
            end
            S_CONF_M: begin
                mul_a = conf_d[WIDE_W-1] ? WORD_W'(-conf_d) : WORD_W'(conf_d);
                mul_b = K_SLOPE[WORD_W-1:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // steer the divider and square root starts
    always_comb begin
        div_start = 1'b0;
        div_num   = mul_p;
        div_den   = MS_PER_S[WORD_W-1:0];
        unique case (r_st)
            S_RATE_D, S_ST_D: begin
                div_start = 1'b1;
                div_num   = mul_p + MS_HALF;
            end
            S_SC_D: begin
                div_start = 1'b1;
                div_den   = r_len;
            end
            S_AC_D: begin
                div_start = 1'b1;
                div_den   = WORD_W'(per);
            end
            default: div_start = 1'b0;
        endcase
    end

    assign sq_start = (r_st == S_SQ_S);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= RST_PERIOD;
            r_speed  <= RST_SPEED;
            r_accel  <= RST_ACCEL;
            r_turn   <= RST_TURN;
            r_gripr  <= RST_GRIP;
            r_pgain  <= RST_PGAIN;
            r_dgain  <= RST_DGAIN;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_PERIOD: r_period <= i_cfg_wdata[PER_W-1:0];
                CFG_SPEED:  r_speed  <= i_cfg_wdata;
                CFG_ACCEL:  r_accel  <= i_cfg_wdata;
                CFG_TURN:   r_turn   <= i_cfg_wdata;
                CFG_GRIP:   r_gripr  <= i_cfg_wdata;
                CFG_PGAIN:  r_pgain  <= i_cfg_wdata;
                CFG_DGAIN:  r_dgain  <= i_cfg_wdata;
                default:    r_period <= r_period;
            endcase
        end
    end

    // sequencer, pose state and output register
    always_ff @(posedge i_clk) begin
        logic signed [WIDE_W-1:0] v64;
        logic signed [WIDE_W-1:0] m64;
        logic signed [WIDE_W-1:0] d64;
        logic signed [WIDE_W-1:0] e0;
        logic signed [WIDE_W-1:0] e1;
        logic signed [WORD_W-1:0] np;
        logic [WIDE_W-1:0]        eu;
        logic [WORD_W-1:0]        q32;
        logic                     big;
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ret    <= S_IDLE;
            r_ph     <= PH_DSR;
            r_ax     <= '0;
            r_k      <= '0;
            r_ovalid <= 1'b0;
            r_time   <= '0;
            r_grip   <= '0;
            r_err    <= '0;
            r_reach  <= 1'b0;
            r_conf   <= '0;
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
                r_acc[i] <= '0;
                r_ang[i] <= '0;
            end
        end else begin
            // drop a delivered result unless a new one replaces it
            if (r_ovalid && i_out_ready && (r_st != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (in_acc) begin
                        r_g[0]  <= i_goal_x;
                        r_g[1]  <= i_goal_y;
                        r_g[2]  <= i_goal_z;
                        r_ga[0] <= i_goal_yaw;
                        r_ga[1] <= i_goal_pitch;
                        r_ga[2] <= i_goal_roll;
                        r_gg    <= i_goal_grip;
                        r_tol   <= (i_goal_tolerance == '0) ? K_TOL[LIM_W-1:0]
                                                            : i_goal_tolerance;
                        r_hold  <= i_hold;
                        r_k     <= '0;
                        if (i_func) begin
                            r_time   <= i_goal_time;
                            r_pos[0] <= i_goal_x;
                            r_pos[1] <= i_goal_y;
                            r_pos[2] <= i_goal_z;
                            r_ang[0] <= i_goal_yaw;
                            r_ang[1] <= i_goal_pitch;
                            r_ang[2] <= i_goal_roll;
                            for (int i = 0; i < 3; i++) begin
                                r_vel[i] <= '0;
                                r_acc[i] <= '0;
                            end
                            r_grip  <= i_goal_grip;
                            r_err   <= '0;
                            r_reach <= 1'b1;
                            r_conf  <= i_hold ? QONE[GRIP_W-1:0] : K_LOADC[GRIP_W-1:0];
                            r_st    <= S_DONE;
                        end else begin
                            r_time <= r_time + WORD_W'(per);
                            if (i_hold) begin
                                for (int i = 0; i < 3; i++) begin
                                    r_vel[i] <= '0;
                                    r_acc[i] <= '0;
                                end
                                r_conf <= QONE[GRIP_W-1:0];
                                r_st   <= S_ERR_L;
                            end else begin
                                r_st <= S_RATE_M;
                            end
                        end
                    end
                end
                // per-tick limits: accel cap, step cap, turn and grip steps
                S_RATE_M: r_st <= S_RATE_D;
                S_RATE_D: begin
                    r_ret <= S_RATE_P;
                    r_st  <= S_DIVW;
                end
                S_RATE_P: begin
                    r_lim[r_k] <= div_quo[WORD_W-1:0];
                    r_k        <= r_k + 1'b1;
                    if (r_k == 2'd3) begin
                        r_ax <= '0;
                        r_st <= S_PD_A;
                    end else begin
                        r_st <= S_RATE_M;
                    end
                end
                // velocity demand, one axis at a time
                S_PD_A: r_st <= S_PD_B;
                S_PD_B: begin
                    r_t  <= mulq_fin(mul_p, pd_e[WORD_W-1]);
                    r_st <= S_PD_C;
                end
                S_PD_C: begin
                    r_vec[r_ax] <= sat32(r_t - mulq_fin(mul_p, r_vel[r_ax][WORD_W-1]));
                    if (r_ax == 2'd2) begin
                        r_ax  <= '0;
                        r_sum <= '0;
                        r_ph  <= PH_DSR;
                        r_st  <= S_SQ_M;
                    end else begin
                        r_ax <= r_ax + 1'b1;
                        r_st <= S_PD_A;
                    end
                end
                // sum of squares, then square root
                S_SQ_M: r_st <= S_SQ_A;
                S_SQ_A: begin
                    r_sum <= r_sum + mul_p;
                    if (r_ax == 2'd2) begin
                        r_st <= S_SQ_S;
                    end else begin
                        r_ax <= r_ax + 1'b1;
                        r_st <= S_SQ_M;
                    end
                end
                S_SQ_S: r_st <= S_SQW;
                S_SQW: begin
                    if (sq_done) begin
                        r_len <= sq_root;
                        r_ax  <= '0;
                        unique case (r_ph)
                            PH_DSR, PH_DV: begin
                                if (sq_root != '0 && sq_root > cap) begin
                                    r_st <= S_SC_M;
                                end else begin
                                    r_st <= (r_ph == PH_DSR) ? S_DV : S_VEL;
                                end
                            end
                            PH_EP: begin
                                r_elen <= sq_root;
                                for (int i = 0; i < 3; i++) begin
                                    r_vec[i] <= sat32(WIDE_W'(r_ga[i]) - WIDE_W'(r_ang[i]));
                                end
                                r_sum <= '0;
                                r_ph  <= PH_EA;
                                r_st  <= S_SQ_M;
                            end
                            default: r_st <= S_ERR_R;
                        endcase
                    end
                end
                // scale the vector down to its cap
                S_SC_M: r_st <= S_SC_D;
                S_SC_D: begin
                    r_ret <= S_SC_P;
                    r_st  <= S_DIVW;
                end
                S_SC_P: begin
                    q32 = div_qs_mag[WORD_W-1:0];
                    r_vec[r_ax] <= r_vec[r_ax][WORD_W-1] ? $signed(~q32 + 1'b1)
                                                          : $signed(q32);
                    if (r_ax == 2'd2) begin
                        r_ax <= '0;
                        r_st <= (r_ph == PH_DSR) ? S_DV : S_VEL;
                    end else begin
                        r_ax <= r_ax + 1'b1;
                        r_st <= S_SC_M;
                    end
                end
                // velocity change toward the demand
                S_DV: begin
                    for (int i = 0; i < 3; i++) begin
                        r_vec[i] <= sat32(WIDE_W'(r_vec[i]) - WIDE_W'(r_vel[i]));
                    end
                    r_ax  <= '0;
                    r_sum <= '0;
                    r_ph  <= PH_DV;
                    r_st  <= S_SQ_M;
                end
                // integrate one axis: velocity, acceleration, position
                S_VEL: begin
                    r_vel[r_ax] <= sat32(WIDE_W'(r_vel[r_ax]) + WIDE_W'(r_vec[r_ax]));
                    r_st        <= S_AC_M;
                end
                S_AC_M: r_st <= S_AC_D;
                S_AC_D: begin
                    r_ret <= S_AC_P;
                    r_st  <= S_DIVW;
                end
                S_AC_P: begin
                    v64 = r_vec[r_ax][WORD_W-1] ? -$signed(div_quo) : $signed(div_quo);
                    r_acc[r_ax] <= sat32(v64);
                    r_st        <= S_ST_M;
                end
                S_ST_M: r_st <= S_ST_D;
                S_ST_D: begin
                    r_ret <= S_ST_P;
                    r_st  <= S_DIVW;
                end
                S_ST_P: begin
                    v64 = r_vel[r_ax][WORD_W-1] ? -$signed(div_quo) : $signed(div_quo);
                    m64 = $signed(WIDE_W'(r_lim[1]));
                    if (v64 > m64) begin
                        v64 = m64;
                    end else if (v64 < -m64) begin
                        v64 = -m64;
                    end
                    e0 = WIDE_W'(r_g[r_ax]) - WIDE_W'(r_pos[r_ax]);
                    np = sat32(WIDE_W'(r_pos[r_ax]) + v64);
                    e1 = WIDE_W'(r_g[r_ax]) - WIDE_W'(np);
                    // snap to the target when the step crosses it
                    if ((e0 > 0 && e1 < 0) || (e0 < 0 && e1 > 0)) begin
                        r_pos[r_ax] <= r_g[r_ax];
                        r_vel[r_ax] <= '0;
                    end else begin
                        r_pos[r_ax] <= np;
                    end
                    if (r_ax == 2'd2) begin
                        r_st <= S_TURN;
                    end else begin
                        r_ax <= r_ax + 1'b1;
                        r_st <= S_VEL;
                    end
                end
                // rate-limit angles and grip
                S_TURN: begin
                    m64 = $signed(WIDE_W'(r_lim[2]));
                    for (int i = 0; i < 3; i++) begin
                        d64 = WIDE_W'(r_ga[i]) - WIDE_W'(r_ang[i]);
                        if (d64 > m64) begin
                            v64 = WIDE_W'(r_ang[i]) + m64;
                        end else if (d64 < -m64) begin
                            v64 = WIDE_W'(r_ang[i]) - m64;
                        end else begin
                            v64 = WIDE_W'(r_ga[i]);
                        end
                        r_ang[i] <= v64[WORD_W-1:0];
                    end
                    m64 = $signed(WIDE_W'(r_lim[3]));
                    if (grip_d > m64) begin
                        v64 = $signed(WIDE_W'(r_grip)) + m64;
                    end else if (grip_d < -m64) begin
                        v64 = $signed(WIDE_W'(r_grip)) - m64;
                    end else begin
                        v64 = $signed(WIDE_W'(r_gg));
                    end
                    if (v64 < 0) begin
                        v64 = '0;
                    end else if (v64 > $signed(QONE)) begin
                        v64 = $signed(QONE);
                    end
                    r_grip <= v64[GRIP_W-1:0];
                    r_st   <= S_ERR_L;
                end
                // pose error: position length, angle length, grip
                S_ERR_L: begin
                    for (int i = 0; i < 3; i++) begin
                        r_vec[i] <= sat32(WIDE_W'(r_g[i]) - WIDE_W'(r_pos[i]));
                    end
                    r_ax  <= '0;
                    r_sum <= '0;
                    r_ph  <= PH_EP;
                    r_st  <= S_SQ_M;
                end
                S_ERR_R: r_st <= S_ERR_G;
                S_ERR_G: begin
                    r_esum <= WIDE_W'(r_elen) + WIDE_W'(mulq_fin(mul_p, 1'b0));
                    r_st   <= S_ERR_F;
                end
                S_ERR_F: begin
                    eu  = r_esum + WIDE_W'(mulq_fin(mul_p, 1'b0));
                    big = (eu > M32);
                    q32 = big ? M32[WORD_W-1:0] : eu[WORD_W-1:0];
                    r_err   <= q32;
                    r_reach <= (q32 <= WORD_W'(r_tol));
                    r_st    <= r_hold ? S_DONE : S_CONF_M;
                end
                S_CONF_M: r_st <= S_CONF_P;
                S_CONF_P: begin
                    v64 = $signed(K_BASE) + mulq_fin(mul_p, conf_d[WIDE_W-1]);
                    if (v64 < $signed(K_LOW)) begin
                        v64 = $signed(K_LOW);
                    end else if (v64 > $signed(K_HIGH)) begin
                        v64 = $signed(K_HIGH);
                    end
                    r_conf <= v64[GRIP_W-1:0];
                    r_st   <= S_DONE;
                end
                // hand the result to the output register
                S_DONE: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_ovalid  <= 1'b1;
                        r_o_time  <= r_time;
                        for (int i = 0; i < 3; i++) begin
                            r_o_pos[i] <= r_pos[i];
                            r_o_ang[i] <= r_ang[i];
                        end
                        r_o_grip  <= r_grip;
                        r_o_err   <= r_err;
                        r_o_reach <= r_reach;
                        r_o_conf  <= r_conf;
                        r_st      <= S_IDLE;
                    end
                end
                S_DIVW: begin
                    if (div_done) begin
                        r_st <= r_ret;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready   = (r_st == S_IDLE);
    assign o_out_valid  = r_ovalid;
    assign o_now_ms     = r_o_time;
    assign o_pos_x      = r_o_pos[0];
    assign o_pos_y      = r_o_pos[1];
    assign o_pos_z      = r_o_pos[2];
    assign o_ang_yaw    = r_o_ang[0];
    assign o_ang_pitch  = r_o_ang[1];
    assign o_ang_roll   = r_o_ang[2];
    assign o_grip_level = r_o_grip;
    assign o_pose_error = r_o_err;
    assign o_reached    = r_o_reach;
    assign o_confidence = r_o_conf;

    // the block stays busy for the cycle after it takes a word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("input ready right after an accepted word");

    // the divider finishes only while the sequencer waits on it
    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_st == S_DIVW))
        else $error("divider result arrived outside its wait state");

    // the square root finishes only while the sequencer waits on it
    a_sqrt_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done |-> (r_st == S_SQW))
        else $error("square root result arrived outside its wait state");

    // confidence never exceeds one
    a_conf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (WIDE_W'(o_confidence) <= QONE))
        else $error("confidence above one");

endmodule
`default_nettype wire
